FILE: hw/rtl/rse_pkg.sv
// Package for the Reed-Solomon parity encoder: field constants, widths,
// the GF(256) multiply function and the control struct for the cell row.
// No dependencies.
package rse_pkg;

  localparam int ByteW       = 8;
  localparam int CfgW        = 6;
  localparam int MaxParity   = 32;
  localparam int ParityReset = 10;

  // Low byte of the field polynomial x^8+x^4+x^3+x^2+1 (0x11D).
  localparam logic [ByteW-1:0] GfPolyLow = 8'h1D;
  // Primitive element of the field.
  localparam logic [ByteW-1:0] GfAlpha   = 8'h02;

  // Control broadcast to every cell of the row.
  typedef struct packed {
    logic             clear;    // zero the remainder byte
    logic             init;     // load the starting generator coefficient
    logic             gen_en;   // one generator product step
    logic             rem_en;   // one remainder shift step
    logic [ByteW-1:0] operand;  // multiplier operand: root, feedback or zero
  } cell_ctrl_t;

  // GF(256) multiply, shift-and-reduce from the top bit of b down.
  function automatic logic [ByteW-1:0] gf_mul(logic [ByteW-1:0] a, logic [ByteW-1:0] b);
    logic [ByteW-1:0] acc;
    acc = '0;
    for (int k = ByteW - 1; k >= 0; k--) begin
      acc = {acc[ByteW-2:0], 1'b0} ^ (acc[ByteW-1] ? GfPolyLow : '0);
      acc = acc ^ (b[k] ? a : '0);
    end
    return acc;
  endfunction

endpackage

FILE: hw/rtl/rse_data_if.sv
// Stream interface for message bytes going into the encoder.
// Depends on rse_pkg for the byte width.
interface rse_data_if;
  logic                      valid;
  logic                      ready;
  logic [rse_pkg::ByteW-1:0] data_byte;
  logic                      block_end;

  modport source (output valid, output data_byte, output block_end, input ready);
  modport sink   (input valid, input data_byte, input block_end, output ready);
endinterface

FILE: hw/rtl/rse_parity_if.sv
// Stream interface for parity bytes coming out of the encoder.
// Depends on rse_pkg for the byte width.
interface rse_parity_if;
  logic                      valid;
  logic                      ready;
  logic [rse_pkg::ByteW-1:0] parity_byte;
  logic                      parity_last;

  modport source (output valid, output parity_byte, output parity_last, input ready);
  modport sink   (input valid, input parity_byte, input parity_last, output ready);
endinterface

FILE: hw/rtl/rse_cell.sv
// One cell of the encoder row: a remainder byte and a generator coefficient
// sharing one GF(256) multiplier. Depends on rse_pkg.
module rse_cell (
  input  logic                      clk_i,
  input  rse_pkg::cell_ctrl_t       ctrl_i,
  input  logic                      is_top_i,
  input  logic [rse_pkg::ByteW-1:0] rem_nb_i,
  input  logic [rse_pkg::ByteW-1:0] gen_nb_i,
  output logic [rse_pkg::ByteW-1:0] rem_o,
  output logic [rse_pkg::ByteW-1:0] gen_o
);

  logic [rse_pkg::ByteW-1:0] rem_q, rem_d;
  logic [rse_pkg::ByteW-1:0] gen_q, gen_d;
  logic [rse_pkg::ByteW-1:0] prod;

  // The multiplier serves both the generator build and the remainder fold.
  assign prod = rse_pkg::gf_mul(gen_q, ctrl_i.operand);

  // Remainder: take the neighbor's byte and add the feedback product.
  always_comb begin
    if (ctrl_i.clear) begin
      rem_d = '0;
    end else if (ctrl_i.rem_en) begin
      rem_d = rem_nb_i ^ prod;
    end else begin
      rem_d = rem_q;
    end
  end

  // Generator: multiply by the current root and add the neighbor's old value.
  always_comb begin
    if (ctrl_i.init) begin
      gen_d = {{(rse_pkg::ByteW-1){1'b0}}, is_top_i};
    end else if (ctrl_i.gen_en) begin
      gen_d = gen_nb_i ^ prod;
    end else begin
      gen_d = gen_q;
    end
  end

  // Datapath registers; the controller's init state sets them after reset.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    gen_q <= gen_d;
  end

  assign rem_o = rem_q;
  assign gen_o = gen_q;

endmodule

FILE: hw/rtl/reed_solomon_ecc_encoder_core.sv
// Reed-Solomon parity encoder over GF(256), field polynomial 0x11D.
// Top level: control sequencer and the row of rse_cell instances.
// Depends on rse_pkg, rse_data_if, rse_parity_if and rse_cell.
//
// Systematic RS parity encoder with a configurable parity length L (1 to
// MAX_PARITY, a written 0 counts as 1, larger values saturate). After reset
// and after every write of the length register the block builds the
// generator polynomial, with data ready held low; the write also
// drops any block in progress. Message bytes are then taken one per cycle,
// each folded into all L remainder bytes at once by the row of multiply-xor
// cells. After the byte marked block_end the block takes no input and shifts
// out the L parity bytes, highest order first, one per cycle that the sink is
// ready, marking the final one; the remainder is empty again afterwards.
module reed_solomon_ecc_encoder_core #(
  parameter int MAX_PARITY = rse_pkg::MaxParity
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [rse_pkg::CfgW-1:0]  cfg_wdata_i,
  rse_data_if.sink                  data_i,
  rse_parity_if.source              parity_o
);

  localparam int LenW     = $clog2(MAX_PARITY + 1);
  localparam int ResetLen = (rse_pkg::ParityReset > MAX_PARITY) ? MAX_PARITY
                                                                : rse_pkg::ParityReset;

  localparam logic [1:0] StInit  = 2'd0;
  localparam logic [1:0] StGen   = 2'd1;
  localparam logic [1:0] StRun   = 2'd2;
  localparam logic [1:0] StDrain = 2'd3;

  logic [1:0]                state_q, state_d;
  logic [LenW-1:0]           len_q, len_d;
  logic [LenW-1:0]           cnt_q, cnt_d;
  logic [rse_pkg::ByteW-1:0] root_q, root_d;
  logic [LenW-1:0]           cfg_len;
  logic                      cnt_at_end;
  logic                      in_acc;
  logic                      out_acc;
  rse_pkg::cell_ctrl_t       ctrl;

  logic [rse_pkg::ByteW-1:0] rem_w [MAX_PARITY];
  logic [rse_pkg::ByteW-1:0] gen_w [MAX_PARITY];

  // Saturate the written length into 1 .. MAX_PARITY.
  always_comb begin
    if (cfg_wdata_i == '0) begin
      cfg_len = LenW'(1);
    end else if (int'(cfg_wdata_i) > MAX_PARITY) begin
      cfg_len = LenW'(MAX_PARITY);
    end else begin
      cfg_len = LenW'(cfg_wdata_i);
    end
  end

  assign cnt_at_end = (LenW'(cnt_q + LenW'(1)) == len_q);
  assign in_acc     = data_i.valid && data_i.ready;
  assign out_acc    = parity_o.valid && parity_o.ready;

  // Sequencer: generator build, data folding and parity drain.
  always_comb begin
    state_d = state_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    root_d  = root_q;
    priority if (cfg_we_i) begin
      len_d   = cfg_len;
      state_d = StInit;
    end else begin
      unique case (state_q)
        StInit: begin
          cnt_d   = '0;
          root_d  = 8'h01;
          state_d = StGen;
        end
        StGen: begin
          root_d = rse_pkg::gf_mul(root_q, rse_pkg::GfAlpha);
          cnt_d  = LenW'(cnt_q + LenW'(1));
          if (cnt_at_end) begin
            state_d = StRun;
          end
        end
        StRun: begin
          cnt_d = '0;
          if (in_acc && data_i.block_end) begin
            state_d = StDrain;
          end
        end
        StDrain: begin
          if (out_acc) begin
            cnt_d = LenW'(cnt_q + LenW'(1));
            if (cnt_at_end) begin
              state_d = StRun;
            end
          end
        end
        default: state_d = StInit;
      endcase
    end
  end

  // Control registers; reset starts a generator build for the reset length.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StInit;
      len_q   <= LenW'(ResetLen);
      cnt_q   <= '0;
      root_q  <= 8'h01;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      root_q  <= root_d;
    end
  end

  // Commands broadcast to the cell row.
  always_comb begin
    ctrl.clear   = (state_q == StInit);
    ctrl.init    = (state_q == StInit);
    ctrl.gen_en  = (state_q == StGen);
    ctrl.rem_en  = in_acc || out_acc;
    unique case (state_q)
      StGen:   ctrl.operand = root_q;
      StRun:   ctrl.operand = data_i.data_byte ^ rem_w[0];
      default: ctrl.operand = '0;
    endcase
  end

  // Row of cells, each fed by its higher-order neighbor; the top cell gets zero.
  for (genvar i = 0; i < MAX_PARITY; i++) begin : g_cell
    logic [rse_pkg::ByteW-1:0] rem_nb;
    logic [rse_pkg::ByteW-1:0] gen_nb;
    if (i == MAX_PARITY - 1) begin : g_end
      assign rem_nb = '0;
      assign gen_nb = '0;
    end else begin : g_mid
      assign rem_nb = rem_w[i+1];
      assign gen_nb = gen_w[i+1];
    end
    rse_cell u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .is_top_i (LenW'(i + 1) == len_q),
      .rem_nb_i (rem_nb),
      .gen_nb_i (gen_nb),
      .rem_o    (rem_w[i]),
      .gen_o    (gen_w[i])
    );
  end

  // Stream ports.
  assign data_i.ready         = (state_q == StRun);
  assign parity_o.valid       = (state_q == StDrain);
  assign parity_o.parity_byte = rem_w[0];
  assign parity_o.parity_last = cnt_at_end;

`ifndef SYNTHESIS
  // Input is never taken while parity bytes are pending.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    parity_o.valid |-> !data_i.ready)
    else $error("input ready while parity is draining");

  // A block end starts the parity drain.
  a_drain_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && data_i.block_end && !cfg_we_i) |=> parity_o.valid)
    else $error("no parity after block end");

  // The final parity byte ends the drain.
  a_drain_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && parity_o.parity_last) |=> !parity_o.valid)
    else $error("parity continues after last byte");

  // A length write always triggers a generator rebuild.
  a_cfg_rebuild: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (!data_i.ready && !parity_o.valid))
    else $error("block usable right after length write");
`endif

endmodule
